// ===== rtl/core/two_stage_clock_divider_search_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the clock divider search checker
// Short forms for the implication properties that the checker uses
// ----------------------------------------------------------------------------
`ifndef TWO_STAGE_CLOCK_DIVIDER_SEARCH_MACROS_SVH
`define TWO_STAGE_CLOCK_DIVIDER_SEARCH_MACROS_SVH

// same-cycle implication
`define TSCDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TSCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/tscds_pkg.sv =====
// ----------------------------------------------------------------------------
// tscds_pkg
// Constants and types shared by the divider search cells and control
// ----------------------------------------------------------------------------
`default_nettype none

package tscds_pkg;

    localparam int POST_DIV_STEPS = 256;
    // generator divider limit, a power of two
    localparam int GEN_DIV_MAX    = 256;

    localparam int IDX_W     = $clog2(POST_DIV_STEPS);
    localparam int GEN_BITS  = $clog2(GEN_DIV_MAX);
    localparam int NUM_CELLS = GEN_BITS + 1;
    localparam int SHAMT_W   = $clog2(NUM_CELLS);
    localparam int QUO_W     = GEN_BITS + 1;
    localparam int DIV_W     = 9;
    localparam int HZ_W      = 32;
    localparam int STEP_W    = HZ_W + DIV_W;

    localparam longint RATIO_LIMIT = longint'(GEN_DIV_MAX) * 2 * longint'(POST_DIV_STEPS - 1);
    localparam int     LIMIT_W     = $clog2(RATIO_LIMIT + 1);
    localparam int     BOUND_W     = HZ_W + 1 + LIMIT_W;

    // one post divider candidate moving down the chain
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             ok;
        logic [HZ_W-1:0]  step;
        logic [HZ_W-1:0]  rem;
        logic [QUO_W-1:0] quo;
        logic [DIV_W-1:0] post;
    } tscds_token_t;

    typedef struct packed {
        logic             found;
        logic [DIV_W-1:0] post;
        logic [DIV_W-1:0] gen;
        logic [HZ_W-1:0]  excess;
    } tscds_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/two_stage_clock_divider_search.sv =====
// ----------------------------------------------------------------------------
// two_stage_clock_divider_search
// Finds the post and generator divider pair with the smallest overshoot
// ----------------------------------------------------------------------------
//  channel   signals                                        handshake
//  request   source_hz, target_hz                           in_valid / in_ready
//  result    found, post_divider, generator_divider,        out_valid / out_ready
//            excess_hz
//
//  One candidate per cycle enters a row of nine division cells; a request holds
//  the issue stage until its last candidate has been sent, and the next request
//  is taken only after that. Up to two results are held at the output, so an
//  output stall only blocks new requests once two are outstanding.
//  Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module two_stage_clock_divider_search
    import tscds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [HZ_W-1:0]   source_hz,
    input  wire logic [HZ_W-1:0]   target_hz,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic [DIV_W-1:0]       post_divider,
    output logic [DIV_W-1:0]       generator_divider,
    output logic [HZ_W-1:0]        excess_hz
);

    logic           busy;
    logic           load;
    logic           pop;
    logic [1:0]     outst_reg;
    tscds_token_t   tok [NUM_CELLS+1];
    tscds_result_t  res;

    // outstanding request count bounds the result queue
    assign load     = in_valid && in_ready;
    assign pop      = out_valid && out_ready;
    assign in_ready = !busy && (outst_reg < 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else if (load && !pop)
        begin
            outst_reg <= outst_reg + 2'd1;
        end
        else if (pop && !load)
        begin
            outst_reg <= outst_reg - 2'd1;
        end
    end

    tscds_issue u_issue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .source_hz (source_hz),
        .target_hz (target_hz),
        .busy      (busy),
        .tok       (tok[0])
    );

    // division cells, overflow bit first
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        tscds_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shamt   (SHAMT_W'(NUM_CELLS - 1 - k)),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    tscds_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok[NUM_CELLS]),
        .pop       (pop),
        .res_valid (out_valid),
        .res       (res)
    );

    assign found             = res.found;
    assign post_divider      = res.post;
    assign generator_divider = res.gen;
    assign excess_hz         = res.excess;

endmodule

`default_nettype wire

// ===== rtl/core/tscds_issue.sv =====
// ----------------------------------------------------------------------------
// tscds_issue
// Holds the request and sends one post divider candidate per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tscds_issue
    import tscds_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic [HZ_W-1:0]    source_hz,
    input  wire logic [HZ_W-1:0]    target_hz,
    output logic                    busy,
    output tscds_token_t            tok
);

    logic              busy_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [HZ_W-1:0]   src_reg;
    logic [HZ_W-1:0]   tgt_reg;
    logic              rej_reg;
    tscds_token_t      tok_reg;
    tscds_token_t      tok_next;

    logic [BOUND_W-1:0] bound;
    logic               rej_next;
    logic [DIV_W-1:0]   post;
    logic [STEP_W-1:0]  prod;
    logic               idx_last;

    // reject check: a zero input, source below target, or source >= (target + 1) * limit (too fast)
    always_comb
    begin
        bound = BOUND_W'({1'b0, target_hz} + (HZ_W+1)'(1)) * BOUND_W'(RATIO_LIMIT);
        rej_next = (source_hz == '0) || (target_hz == '0) || (source_hz < target_hz)
                   || (BOUND_W'(source_hz) >= bound);
    end

    // candidate product
    always_comb
    begin
        idx_last = (idx_reg == IDX_W'(POST_DIV_STEPS - 1));
        post = (idx_reg == '0) ? DIV_W'(1) : DIV_W'({idx_reg, 1'b0});
        prod = STEP_W'(post) * STEP_W'(tgt_reg);
        tok_next.valid = busy_reg;
        tok_next.first = (idx_reg == '0);
        tok_next.last  = idx_last;
        tok_next.ok    = !rej_reg && (prod <= STEP_W'(src_reg));
        tok_next.step  = prod[HZ_W-1:0];
        tok_next.rem   = src_reg - HZ_W'(1);
        tok_next.quo   = '0;
        tok_next.post  = post;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (idx_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            src_reg <= source_hz;
            tgt_reg <= target_hz;
            rej_reg <= rej_next;
        end
    end

    assign busy = busy_reg;
    assign tok  = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tscds_cell.sv =====
// ----------------------------------------------------------------------------
// tscds_cell
// One restoring division step: resolves one quotient bit per candidate
// ----------------------------------------------------------------------------
`default_nettype none

module tscds_cell
    import tscds_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SHAMT_W-1:0]  shamt,
    input  wire tscds_token_t        tok_in,
    output tscds_token_t             tok_out
);

    tscds_token_t                tok_reg;
    tscds_token_t                tok_next;
    logic [HZ_W+GEN_BITS-1:0]    trial;
    logic                        fits;

    // compare shifted divisor against the running remainder
    always_comb
    begin
        trial    = (HZ_W+GEN_BITS)'(tok_in.step) << shamt;
        fits     = (HZ_W+GEN_BITS)'(tok_in.rem) >= trial;
        tok_next = tok_in;
        tok_next.quo = {tok_in.quo[QUO_W-2:0], fits};
        if (fits)
        begin
            tok_next.rem = tok_in.rem - trial[HZ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tscds_select.sv =====
// ----------------------------------------------------------------------------
// tscds_select
// Keeps the best candidate of a request and queues finished results
// ----------------------------------------------------------------------------
`default_nettype none

module tscds_select
    import tscds_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tscds_token_t  tok,
    input  wire logic          pop,
    output logic               res_valid,
    output tscds_result_t      res
);

    logic              have_reg;
    logic [DIV_W-1:0]  best_post_reg;
    logic [DIV_W-1:0]  best_gen_reg;
    logic [HZ_W-1:0]   best_exc_reg;
    logic              have_next;
    logic [DIV_W-1:0]  best_post_next;
    logic [DIV_W-1:0]  best_gen_next;
    logic [HZ_W-1:0]   best_exc_next;

    tscds_result_t     head_reg;
    tscds_result_t     tail_reg;
    logic [1:0]        cnt_reg;
    tscds_result_t     push_res;
    logic              push;

    logic              cand;
    logic              have_eff;
    logic [DIV_W-1:0]  gen;
    logic [HZ_W-1:0]   excess;

    // candidate evaluation: gen = quotient + 1, excess = step - rem - 1
    always_comb
    begin
        cand     = tok.valid && tok.ok && !tok.quo[QUO_W-1];
        gen      = DIV_W'(tok.quo[GEN_BITS-1:0]) + DIV_W'(1);
        excess   = tok.step - tok.rem - HZ_W'(1);
        have_eff = have_reg && !tok.first;

        have_next      = have_eff;
        best_post_next = best_post_reg;
        best_gen_next  = best_gen_reg;
        best_exc_next  = best_exc_reg;
        if (cand && (!have_eff || (excess < best_exc_reg)))
        begin
            have_next      = 1'b1;
            best_post_next = tok.post;
            best_gen_next  = gen;
            best_exc_next  = excess;
        end

        push = tok.valid && tok.last;
        push_res.found  = have_next;
        push_res.post   = have_next ? best_post_next : '0;
        push_res.gen    = have_next ? best_gen_next : '0;
        push_res.excess = have_next ? best_exc_next : '0;
    end

    // best tracker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (tok.valid)
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok.valid)
        begin
            best_post_reg <= best_post_next;
            best_gen_reg  <= best_gen_next;
            best_exc_reg  <= best_exc_next;
        end
    end

    // two-entry result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                head_reg <= tail_reg;
                tail_reg <= push_res;
            end
            else
            begin
                head_reg <= push_res;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_reg <= push_res;
            end
            else
            begin
                tail_reg <= push_res;
            end
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
    end

    assign res_valid = (cnt_reg != 2'd0);
    assign res       = head_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tscds_checker.sv =====
// ----------------------------------------------------------------------------
// tscds_checker
// Port-level checks on the divider search results
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_stage_clock_divider_search_macros.svh"

module tscds_checker
    import tscds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic              found,
    input  wire logic [DIV_W-1:0]  post_divider,
    input  wire logic [DIV_W-1:0]  generator_divider,
    input  wire logic [HZ_W-1:0]   excess_hz
);

    // stalled result holds
    `TSCDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(post_divider) && $stable(generator_divider) && $stable(excess_hz))

    // a rejection carries all-zero fields
    `TSCDS_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !found, post_divider == '0 && generator_divider == '0 && excess_hz == '0)

    // a found pair is legal
    `TSCDS_ASSERT_NOW(a_found_legal, clk, rst_n, out_valid && found, (post_divider == DIV_W'(1) || (post_divider != '0 && !post_divider[0])) && generator_divider != '0 && generator_divider <= DIV_W'(GEN_DIV_MAX))

endmodule

bind two_stage_clock_divider_search tscds_checker u_tscds_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .found             (found),
    .post_divider      (post_divider),
    .generator_divider (generator_divider),
    .excess_hz         (excess_hz)
);

`default_nettype wire
